FILE: rtl/core/cbp_pkg.sv
// ============================================================================
// Context bit predictor package
// Guess codes, fill states, table request and result types, and the
// context-to-row mapping of the occurrence counter table.
// ============================================================================
package cbp_pkg;

  // Prediction codes for the next bit of the stream.
  typedef enum logic [1:0] {
    GUESS_ZERO    = 2'd0,
    GUESS_ONE     = 2'd1,
    GUESS_UNKNOWN = 2'd2
  } guess_t;

  // History fill sequence: two picks fill the history, then full steps.
  typedef enum logic [2:0] {
    FILL_FIRST  = 3'b001,
    FILL_SECOND = 3'b010,
    RUNNING     = 3'b100
  } fill_state_t;

  // Margin register.
  localparam int MARGIN_W = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd1;

  // Counter table: one row per context, two counters (next bit 0 and 1) per row.
  localparam int CTX_ROWS  = 36;
  localparam int ROW_IDX_W = 6;

  // Result queue.
  localparam int RES_DEPTH = 3;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 2;

  typedef logic [ROW_IDX_W-1:0] row_idx_t;

  // Write and read request to the counter table.
  typedef struct packed {
    logic     wr_en;
    row_idx_t wr_row;
    logic     rd_en;
    row_idx_t rd_row;
  } tbl_req_t;

  // One result item.
  typedef struct packed {
    guess_t next_guess;
    logic   hit;
    logic   primed;
  } result_t;

  // Row of a context: older pick, older guess, newer pick, newer guess.
  function automatic row_idx_t ctx_row(logic op, guess_t og, logic np, guess_t ng);
    row_idx_t a;
    row_idx_t b;
    row_idx_t c;
    a = {5'd0, op} * 6'd3 + {4'd0, og};
    b = a * 6'd2 + {5'd0, np};
    c = b * 6'd3 + {4'd0, ng};
    return c;
  endfunction

endpackage

FILE: rtl/core/cbp_in_if.sv
// ============================================================================
// Context bit predictor input channel
// Valid/ready channel that carries one observed bit per item.
// ============================================================================
interface cbp_in_if;
  logic valid;
  logic ready;
  logic pick;

  modport source (output valid, output pick, input ready);
  modport sink (input valid, input pick, output ready);
endinterface

FILE: rtl/core/cbp_out_if.sv
// ============================================================================
// Context bit predictor result channel
// Valid/ready channel that carries one prediction result per item.
// ============================================================================
interface cbp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] next_guess;
  logic       hit;
  logic       primed;

  modport source (output valid, output next_guess, output hit, output primed, input ready);
  modport sink (input valid, input next_guess, input hit, input primed, output ready);
endinterface

FILE: rtl/core/cbp_count_table.sv
// ============================================================================
// Occurrence counter table
// One row per context holding the counters for next bit 0 and 1. Row valid
// bits make every row read as zero after reset. The read data is
// registered and a write to the row being read is forwarded.
// ============================================================================
module cbp_count_table import cbp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tbl_req_t                req,
  input  logic [2*COUNT_BITS-1:0] wr_data,
  output logic [2*COUNT_BITS-1:0] rd_data
);

  logic [2*COUNT_BITS-1:0] mem [CTX_ROWS];
  logic [CTX_ROWS-1:0]     row_vld_r;
  logic [2*COUNT_BITS-1:0] rd_data_r;

  // Row storage.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= wr_data;
    end
  end

  // A row holds real counts once it has been written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (req.wr_en) begin
      row_vld_r[req.wr_row] <= 1'b1;
    end
  end

  // Registered read with forwarding of a same-cycle write.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && (req.wr_row == req.rd_row)) begin
        rd_data_r <= wr_data;
      end else if (row_vld_r[req.rd_row]) begin
        rd_data_r <= mem[req.rd_row];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/cbp_result_fifo.sv
// ============================================================================
// Result queue
// Small queue of result items in front of the result channel, so that the
// input side keeps accepting while the receiver stalls.
// ============================================================================
module cbp_result_fifo import cbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  result_t              push_data,
  output logic [RES_CNT_W-1:0] level,
  cbp_out_if.source            out_ch
);

  result_t              slot_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r;
  logic [RES_PTR_W-1:0] rd_ptr_r;
  logic [RES_CNT_W-1:0] count_r;
  logic                 pop;

  assign pop = out_ch.valid && out_ch.ready;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_r + RES_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_r + RES_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + RES_CNT_W'(1);
        2'b01:   count_r <= count_r - RES_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Head of the queue drives the channel.
  assign out_ch.valid      = (count_r != '0);
  assign out_ch.next_guess = slot_r[rd_ptr_r].next_guess;
  assign out_ch.hit        = slot_r[rd_ptr_r].hit;
  assign out_ch.primed     = slot_r[rd_ptr_r].primed;
  assign level             = count_r;

endmodule

FILE: rtl/core/context_bit_predictor.sv
// ============================================================================
// Context bit predictor
// Predicts the next bit of a stream from occurrence counts of short contexts.
// ============================================================================
// Usage:
//   in_ch carries one observed bit (pick) per item; out_ch returns one result
//   per item: the guess for the next bit (0, 1 or 2 for unknown), whether the
//   pending guess matched this pick, and whether the history was full.
//   cfg_wr_en/cfg_wr_data write the 8-bit margin; write it only while idle.
//   Path: a result passes the result stage register and then the result
//   queue before out_ch can take it.
//   Throughput: one item per cycle while in_ch.ready is high. The counter
//   table does one read-modify-write per item: the counters of the current
//   context sit in the table's read register, the incremented row is written
//   back and the row of the next context is read in the same cycle, with the
//   guess formed from that read register in the following cycle.
//   Reset: history, pending guess and margin return to their reset values
//   and all table rows read as zero at once; in_ch.ready rises right after.
//   Stall: results queue in a three-entry buffer; in_ch.ready is low while
//   three results are held or on their way, and rises after the edge at
//   which out_ch takes one.
// ============================================================================
module context_bit_predictor import cbp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  cbp_in_if.sink              in_ch,
  cbp_out_if.source           out_ch,
  input  logic                cfg_wr_en,
  input  logic [MARGIN_W-1:0] cfg_wr_data
);

  localparam int CMP_W = (COUNT_BITS > MARGIN_W) ? COUNT_BITS : MARGIN_W;

  logic [MARGIN_W-1:0]     margin_r;
  fill_state_t             fill_state_r;
  logic                    older_pick_r;
  logic                    newer_pick_r;
  guess_t                  older_guess_r;
  guess_t                  newer_guess_r;
  guess_t                  pend_guess_r;
  logic                    pend_fresh_r;
  logic                    b_valid_r;
  logic                    b_hit_r;
  logic                    b_primed_r;

  logic                    in_acc;
  logic                    running;
  tbl_req_t                tbl_req;
  logic [2*COUNT_BITS-1:0] tbl_rd_data;
  logic [2*COUNT_BITS-1:0] tbl_wr_data;
  logic [COUNT_BITS-1:0]   cnt0;
  logic [COUNT_BITS-1:0]   cnt1;
  logic [COUNT_BITS-1:0]   cnt_sel;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic [COUNT_BITS-1:0]   cnt_diff;
  logic [CMP_W-1:0]        mag_ext;
  logic [CMP_W-1:0]        margin_ext;
  guess_t                  calc_guess;
  guess_t                  pend_now;
  logic                    hit_now;
  logic [RES_CNT_W-1:0]    res_level;
  logic [RES_CNT_W:0]      occupancy;
  result_t                 res_push_data;

  // Handshake: room is kept for every result still in flight.
  assign occupancy   = {1'b0, res_level} + {{RES_CNT_W{1'b0}}, b_valid_r};
  assign in_ch.ready = (occupancy < (RES_CNT_W + 1)'(RES_DEPTH));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign running     = (fill_state_r == RUNNING);

  // Margin register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      margin_r <= cfg_wr_data;
    end
  end

  // Guess from the counters of the current context.
  assign cnt0       = tbl_rd_data[COUNT_BITS-1:0];
  assign cnt1       = tbl_rd_data[2*COUNT_BITS-1:COUNT_BITS];
  assign cnt_diff   = (cnt0 >= cnt1) ? (cnt0 - cnt1) : (cnt1 - cnt0);
  assign mag_ext    = CMP_W'(cnt_diff);
  assign margin_ext = CMP_W'(margin_r);

  always_comb begin
    if (mag_ext < margin_ext) begin
      calc_guess = GUESS_UNKNOWN;
    end else if (cnt0 < cnt1) begin
      calc_guess = GUESS_ONE;
    end else begin
      calc_guess = GUESS_ZERO;
    end
  end

  // The guess is taken from the table read right after a full step, and
  // held in a register afterwards so that a later margin write leaves it.
  assign pend_now = pend_fresh_r ? calc_guess : pend_guess_r;
  assign hit_now  = ({1'b0, in_ch.pick} == pend_now);

  // Saturating increment of the counter for the old context and this pick.
  assign cnt_sel     = in_ch.pick ? cnt1 : cnt0;
  assign cnt_inc     = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_BITS'(1);
  assign tbl_wr_data = in_ch.pick ? {cnt_inc, cnt0} : {cnt1, cnt_inc};

  // Table access: write back the old context, read the next one.
  always_comb begin
    tbl_req.wr_en  = in_acc && running;
    tbl_req.wr_row = ctx_row(older_pick_r, older_guess_r, newer_pick_r, newer_guess_r);
    tbl_req.rd_en  = in_acc;
    if (running) begin
      tbl_req.rd_row = ctx_row(newer_pick_r, newer_guess_r, in_ch.pick, pend_now);
    end else begin
      tbl_req.rd_row = ctx_row(older_pick_r, older_guess_r, in_ch.pick, GUESS_UNKNOWN);
    end
  end

  cbp_count_table #(
    .COUNT_BITS (COUNT_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tbl_req),
    .wr_data (tbl_wr_data),
    .rd_data (tbl_rd_data)
  );

  // History of picks and their guesses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_state_r  <= FILL_FIRST;
      older_pick_r  <= 1'b0;
      older_guess_r <= GUESS_UNKNOWN;
      newer_pick_r  <= 1'b0;
      newer_guess_r <= GUESS_UNKNOWN;
    end else if (in_acc) begin
      unique case (fill_state_r)
        FILL_FIRST: begin
          older_pick_r  <= in_ch.pick;
          older_guess_r <= GUESS_UNKNOWN;
          fill_state_r  <= FILL_SECOND;
        end
        FILL_SECOND: begin
          newer_pick_r  <= in_ch.pick;
          newer_guess_r <= GUESS_UNKNOWN;
          fill_state_r  <= RUNNING;
        end
        RUNNING: begin
          older_pick_r  <= newer_pick_r;
          older_guess_r <= newer_guess_r;
          newer_pick_r  <= in_ch.pick;
          newer_guess_r <= pend_now;
        end
        default: begin
          fill_state_r <= FILL_FIRST;
        end
      endcase
    end
  end

  // Pending guess and the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_guess_r <= GUESS_UNKNOWN;
      pend_fresh_r <= 1'b0;
      b_valid_r    <= 1'b0;
    end else begin
      pend_guess_r <= pend_now;
      pend_fresh_r <= in_acc && running;
      b_valid_r    <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_hit_r    <= running && hit_now;
      b_primed_r <= running;
    end
  end

  // Result item: the guess is ready in the cycle after the item is taken.
  always_comb begin
    res_push_data.next_guess = b_primed_r ? pend_now : GUESS_UNKNOWN;
    res_push_data.hit        = b_hit_r;
    res_push_data.primed     = b_primed_r;
  end

  cbp_result_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_valid_r),
    .push_data (res_push_data),
    .level     (res_level),
    .out_ch    (out_ch)
  );

  // The result queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (res_level != RES_CNT_W'(RES_DEPTH)))
    else $error("Result pushed into a full queue.");

  // A fresh guess follows a full step taken in the previous cycle.
  a_fresh_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    pend_fresh_r |-> $past(in_acc && running))
    else $error("Fresh guess without a preceding full step.");

  // A primed result is always paired with a fresh table read.
  a_primed_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_primed_r) |-> pend_fresh_r)
    else $error("Primed result without fresh counters.");

endmodule
